FILE: src/rov_yaw_control_and_thruster_mix_assert.svh
// Assertion macros for the ROV yaw control and thruster mix block.
// Included by the checker module; depends on nothing else.
`ifndef ROV_YAW_CONTROL_AND_THRUSTER_MIX_ASSERT_SVH
`define ROV_YAW_CONTROL_AND_THRUSTER_MIX_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define RYWC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define RYWC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define RYWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rywc_pkg.sv
// Shared types, register indexes and Q8.8 arithmetic helpers.
// Used by every module of the yaw control and thruster mix block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rywc_pkg;

    typedef logic signed [15:0] t_q88;
    typedef logic [14:0]        t_lim;
    typedef logic [3:0]         t_reg_idx;

    // Configuration register indexes
    localparam t_reg_idx REG_YAW_SETPOINT    = 4'd0;
    localparam t_reg_idx REG_K_ERROR         = 4'd1;
    localparam t_reg_idx REG_K_RATE          = 4'd2;
    localparam t_reg_idx REG_K_FEEDFORWARD   = 4'd3;
    localparam t_reg_idx REG_YAW_OUT_LIMIT   = 4'd4;
    localparam t_reg_idx REG_SURGE_LIMIT     = 4'd5;
    localparam t_reg_idx REG_YAW_PITCH_LIMIT = 4'd6;
    localparam t_reg_idx REG_ROLL_LIMIT      = 4'd7;

    // Reset values
    localparam t_q88 RST_YAW_SETPOINT  = 16'sd0;
    localparam t_q88 RST_K_ERROR       = 16'sd256;
    localparam t_q88 RST_K_RATE        = 16'sd0;
    localparam t_q88 RST_K_FEEDFORWARD = 16'sd0;
    localparam t_lim RST_LIMIT         = 15'd32767;

    // Defaults for the shared thruster clamp and gain
    localparam t_lim P_THRUSTER_LIMIT = 15'd32767;
    localparam t_q88 P_THRUSTER_GAIN  = 16'sd256;

    // Block configuration as seen by the datapath
    typedef struct packed {
        t_q88 yaw_setpoint;
        t_q88 k_error;
        t_q88 k_rate;
        t_q88 k_feedforward;
        t_lim yaw_out_limit;
        t_lim surge_limit;
        t_lim yaw_pitch_limit;
        t_lim roll_limit;
    } t_cfg;

    // Clamped surge, pitch and roll carried alongside the yaw law
    typedef struct packed {
        t_q88 s;
        t_q88 p;
        t_q88 r;
    } t_cmds;

    // Saturate to 16 bits
    function automatic t_q88 sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Q8.8 product rescale: floor shift by 8, then saturate
    function automatic t_q88 qscale(input logic signed [31:0] p);
        return sat16(signed'(p[31:8]));
    endfunction

    // Symmetric clamp: |x| >= lim gives sign(x)*lim
    function automatic logic signed [17:0] clamp_sym(input logic signed [17:0] x,
                                                     input t_lim lim);
        logic signed [17:0] ax;
        logic signed [17:0] sl;
        ax = x[17] ? -x : x;
        sl = signed'({3'b000, lim});
        if (ax >= sl) begin
            if (x > 18'sd0) begin
                return sl;
            end else if (x < 18'sd0) begin
                return -sl;
            end
            return 18'sd0;
        end
        return x;
    endfunction

    // Clamp a 16-bit value, result stays within 16 bits
    function automatic t_q88 clamp16(input t_q88 x, input t_lim lim);
        logic signed [17:0] c;
        c = clamp_sym(18'(x), lim);
        return c[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/rywc_yaw_law.sv
// Yaw control law pipeline: error, three gain products, sum and clamps.
// Depends on rywc_pkg; also clamps surge, pitch and roll for the mixer.
`timescale 1ns / 1ps
`default_nettype none

module rywc_yaw_law
    import rywc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_q88  i_yaw_angle,
    input  wire t_q88  i_yaw_rate,
    input  wire t_q88  i_surge_cmd,
    input  wire t_q88  i_pitch_cmd,
    input  wire t_q88  i_roll_cmd,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_q88       o_yaw,
    output t_q88       o_yaw_cmd,
    output t_cmds      o_cmds
);

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage payloads
    t_q88  r_err1, r_rate1;
    t_cmds r_cmds1, r_cmds2, r_cmds3, r_cmds4;
    logic signed [31:0] r_pe2, r_pr2, r_pf2;
    t_q88  r_u3;
    t_q88  r_yaw4, r_y4;

    t_q88  n_err1;
    t_cmds n_cmds1;
    logic signed [17:0] sum3;
    t_q88  n_u3;
    t_q88  n_yaw4;

    // per-stage ready: a stage moves when empty or its successor takes
    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: yaw error and command clamps
    always_comb begin
        n_err1    = sat16(24'(i_cfg.yaw_setpoint) - 24'(i_yaw_angle));
        n_cmds1.s = clamp16(i_surge_cmd, i_cfg.surge_limit);
        n_cmds1.p = clamp16(i_pitch_cmd, i_cfg.yaw_pitch_limit);
        n_cmds1.r = clamp16(i_roll_cmd, i_cfg.roll_limit);
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_err1  <= n_err1;
            r_rate1 <= i_yaw_rate;
            r_cmds1 <= n_cmds1;
        end
    end

    // stage 2: the three gain products
    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_pe2   <= r_err1 * i_cfg.k_error;
            r_pr2   <= r_rate1 * i_cfg.k_rate;
            r_pf2   <= i_cfg.yaw_setpoint * i_cfg.k_feedforward;
            r_cmds2 <= r_cmds1;
        end
    end

    // stage 3: rescale products, exact sum, saturate
    always_comb begin
        sum3 = 18'(qscale(r_pe2)) - 18'(qscale(r_pr2)) + 18'(qscale(r_pf2));
        n_u3 = sat16(24'(sum3));
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_u3    <= n_u3;
            r_cmds3 <= r_cmds2;
        end
    end

    // stage 4: output clamp, then the shared yaw/pitch clamp
    assign n_yaw4 = clamp16(r_u3, i_cfg.yaw_out_limit);

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_yaw4  <= n_yaw4;
            r_y4    <= clamp16(n_yaw4, i_cfg.yaw_pitch_limit);
            r_cmds4 <= r_cmds3;
        end
    end

    assign o_valid   = r_v4;
    assign o_yaw     = r_yaw4;
    assign o_yaw_cmd = r_y4;
    assign o_cmds    = r_cmds4;

endmodule

`default_nettype wire

FILE: src/rywc_mixer.sv
// Thruster mixer pipeline: sum/difference mix, clamp, gain and rescale.
// Depends on rywc_pkg; fed by rywc_yaw_law.
`timescale 1ns / 1ps
`default_nettype none

module rywc_mixer
    import rywc_pkg::*;
#(
    parameter t_lim THRUSTER_LIMIT = P_THRUSTER_LIMIT,
    parameter t_q88 THRUSTER_GAIN  = P_THRUSTER_GAIN
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_q88  i_yaw,
    input  wire t_q88  i_yaw_cmd,
    input  wire t_cmds i_cmds,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_q88       o_yaw_drive,
    output t_q88       o_thruster_a,
    output t_q88       o_thruster_b,
    output t_q88       o_thruster_c,
    output t_q88       o_thruster_d
);

    localparam int NTHR = 4;

    logic r_v5, r_v6, r_v7;
    logic rdy5, rdy6, rdy7;

    t_q88 r_yaw5, r_yaw6, r_yaw7;
    t_q88 r_c5 [NTHR];
    logic signed [31:0] r_p6 [NTHR];
    t_q88 r_o7 [NTHR];

    logic signed [17:0] mix [NTHR];
    logic signed [17:0] s, y, p, r;

    assign rdy7    = !r_v7 || i_ready;
    assign rdy6    = !r_v6 || rdy7;
    assign rdy5    = !r_v5 || rdy6;
    assign o_ready = rdy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy5) r_v5 <= i_valid;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    // stage 5: exact mix, then thruster clamp
    always_comb begin
        s = 18'(i_cmds.s);
        y = 18'(i_yaw_cmd);
        p = 18'(i_cmds.p);
        r = 18'(i_cmds.r);
        mix[0] = s + y - p - r;
        mix[1] = s + y + p + r;
        mix[2] = s - y - p + r;
        mix[3] = s - y + p - r;
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && i_valid) begin
            r_yaw5 <= i_yaw;
            for (int i = 0; i < NTHR; i++) begin
                r_c5[i] <= sat16(24'(clamp_sym(mix[i], THRUSTER_LIMIT)));
            end
        end
    end

    // stage 6: gain products
    always_ff @(posedge i_clk) begin
        if (rdy6 && r_v5) begin
            r_yaw6 <= r_yaw5;
            for (int i = 0; i < NTHR; i++) begin
                r_p6[i] <= r_c5[i] * THRUSTER_GAIN;
            end
        end
    end

    // stage 7: rescale into the output register
    always_ff @(posedge i_clk) begin
        if (rdy7 && r_v6) begin
            r_yaw7 <= r_yaw6;
            for (int i = 0; i < NTHR; i++) begin
                r_o7[i] <= qscale(r_p6[i]);
            end
        end
    end

    assign o_valid      = r_v7;
    assign o_yaw_drive  = r_yaw7;
    assign o_thruster_a = r_o7[0];
    assign o_thruster_b = r_o7[1];
    assign o_thruster_c = r_o7[2];
    assign o_thruster_d = r_o7[3];

endmodule

`default_nettype wire

FILE: src/rov_yaw_control_and_thruster_mix.sv
// Top level of the ROV yaw controller and four-thruster mixer.
// Depends on rywc_pkg, rywc_yaw_law and rywc_mixer.
`timescale 1ns / 1ps
`default_nettype none

// One result per input transfer through seven register stages. A new item may
// enter every cycle as long as an output stall has not filled every stage;
// new items are accepted while older ones are still in flight. The depth is
// set by the two multiplier stages (yaw gains, thruster gain), each followed
// by its own rescale/saturate stage, plus the error, clamp and mix stages.
// Each stage holds its item while the next one is full, so output stalls
// back up without loss; input ready drops only when all seven stages are full.
// Configuration writes are always taken (o_cfg_ready is high); indexes
// beyond 7 are ignored, and registers should be written only when the
// pipeline is empty.

module rov_yaw_control_and_thruster_mix
    import rywc_pkg::*;
#(
    parameter t_lim THRUSTER_LIMIT = P_THRUSTER_LIMIT,
    parameter t_q88 THRUSTER_GAIN  = P_THRUSTER_GAIN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire t_reg_idx    i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_q88        i_yaw_angle,
    input  wire t_q88        i_yaw_rate,
    input  wire t_q88        i_surge_cmd,
    input  wire t_q88        i_pitch_cmd,
    input  wire t_q88        i_roll_cmd,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_q88             o_yaw_drive,
    output t_q88             o_thruster_a,
    output t_q88             o_thruster_b,
    output t_q88             o_thruster_c,
    output t_q88             o_thruster_d
);

    t_cfg  r_cfg;
    logic  law_valid, mix_ready;
    t_q88  law_yaw, law_yaw_cmd;
    t_cmds law_cmds;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.yaw_setpoint    <= RST_YAW_SETPOINT;
            r_cfg.k_error         <= RST_K_ERROR;
            r_cfg.k_rate          <= RST_K_RATE;
            r_cfg.k_feedforward   <= RST_K_FEEDFORWARD;
            r_cfg.yaw_out_limit   <= RST_LIMIT;
            r_cfg.surge_limit     <= RST_LIMIT;
            r_cfg.yaw_pitch_limit <= RST_LIMIT;
            r_cfg.roll_limit      <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_YAW_SETPOINT:    r_cfg.yaw_setpoint    <= i_cfg_data;
                REG_K_ERROR:         r_cfg.k_error         <= i_cfg_data;
                REG_K_RATE:          r_cfg.k_rate          <= i_cfg_data;
                REG_K_FEEDFORWARD:   r_cfg.k_feedforward   <= i_cfg_data;
                REG_YAW_OUT_LIMIT:   r_cfg.yaw_out_limit   <= i_cfg_data[14:0];
                REG_SURGE_LIMIT:     r_cfg.surge_limit     <= i_cfg_data[14:0];
                REG_YAW_PITCH_LIMIT: r_cfg.yaw_pitch_limit <= i_cfg_data[14:0];
                REG_ROLL_LIMIT:      r_cfg.roll_limit      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    rywc_yaw_law u_yaw_law (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_yaw_angle (i_yaw_angle),
        .i_yaw_rate  (i_yaw_rate),
        .i_surge_cmd (i_surge_cmd),
        .i_pitch_cmd (i_pitch_cmd),
        .i_roll_cmd  (i_roll_cmd),
        .o_valid     (law_valid),
        .i_ready     (mix_ready),
        .o_yaw       (law_yaw),
        .o_yaw_cmd   (law_yaw_cmd),
        .o_cmds      (law_cmds)
    );

    rywc_mixer #(
        .THRUSTER_LIMIT (THRUSTER_LIMIT),
        .THRUSTER_GAIN  (THRUSTER_GAIN)
    ) u_mixer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (law_valid),
        .o_ready      (mix_ready),
        .i_yaw        (law_yaw),
        .i_yaw_cmd    (law_yaw_cmd),
        .i_cmds       (law_cmds),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_yaw_drive  (o_yaw_drive),
        .o_thruster_a (o_thruster_a),
        .o_thruster_b (o_thruster_b),
        .o_thruster_c (o_thruster_c),
        .o_thruster_d (o_thruster_d)
    );

endmodule

`default_nettype wire

FILE: src/rywc_checker.sv
// Port-level checks for the yaw control and thruster mix top level, with bind.
// Depends on rywc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "rov_yaw_control_and_thruster_mix_assert.svh"

module rywc_checker
    import rywc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_cfg_ready,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_q88 o_yaw_drive,
    input wire t_q88 o_thruster_a
);

    // a stalled result holds its value
    `RYWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_yaw_drive) && $stable(o_thruster_a), "output changed while stalled")

    // input backs up only when the whole pipeline is full and stalled
    `RYWC_ASSERT_IMPL(a_in_stall, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input stalled with room in pipeline")

    // yaw drive is symmetrically clamped, never the most negative code
    `RYWC_ASSERT_NEVER(a_yaw_sym, i_clk, i_rst_n, o_out_valid && (o_yaw_drive == 16'sh8000), "yaw drive outside symmetric clamp")

    // configuration writes are never back-pressured
    `RYWC_ASSERT_NEVER(a_cfg_rdy, i_clk, i_rst_n, !o_cfg_ready, "config port not ready")

endmodule

bind rov_yaw_control_and_thruster_mix rywc_checker u_rywc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_cfg_ready  (o_cfg_ready),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_yaw_drive  (o_yaw_drive),
    .o_thruster_a (o_thruster_a)
);

`default_nettype wire

FILE: verif/rywc_drive_checker.sv
// Checker for the ROV yaw control and thruster mix block: tracks register writes,
// predicts the drive set for every input transfer and compares each output transfer.
// Depends on rywc_pkg only.
`timescale 1ns / 1ps

module rywc_drive_checker
    import rywc_pkg::*;
#(
    parameter int THR_LIMIT = 32767,
    parameter int THR_GAIN  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  t_reg_idx    i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_q88        i_yaw_angle,
    input  t_q88        i_yaw_rate,
    input  t_q88        i_surge_cmd,
    input  t_q88        i_pitch_cmd,
    input  t_q88        i_roll_cmd,
    // output channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_q88        i_yaw_drive,
    input  t_q88        i_thruster_a,
    input  t_q88        i_thruster_b,
    input  t_q88        i_thruster_c,
    input  t_q88        i_thruster_d,
    // status for the test top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // [0] yaw drive, [1..4] thrusters a..d
    typedef logic [4:0][15:0] t_drive_set;

    string field_name [5] = '{"yaw_drive", "thruster_a", "thruster_b",
                              "thruster_c", "thruster_d"};

    t_drive_set drive_queue [$];

    // Shadow copy of the configuration registers
    t_q88 cfg_setpoint;
    t_q88 gain_err;
    t_q88 gain_rate;
    t_q88 gain_ff;
    t_lim lim_yaw;
    t_lim lim_surge;
    t_lim lim_yaw_pitch;
    t_lim lim_roll;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic longint saturate_q(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Q8.8 multiply: floor shift by 8, then saturate
    function automatic longint fixed_mul(input longint a, input longint b);
        longint prod;
        prod = a * b;
        return saturate_q(prod >>> 8);
    endfunction

    // |x| >= lim gives sign(x)*lim, zero stays zero
    function automatic longint clamp_mag(input longint x, input longint lim);
        longint mag;
        mag = (x < 0) ? -x : x;
        if (mag < lim) return x;
        if (x > 0) return lim;
        if (x < 0) return -lim;
        return 0;
    endfunction

    function automatic t_drive_set predict_drives(input t_q88 angle, input t_q88 rate,
                                                  input t_q88 surge, input t_q88 pitch,
                                                  input t_q88 roll);
        longint sp;
        longint err;
        longint law;
        longint yaw_cmd;
        longint s;
        longint y;
        longint p;
        longint r;
        longint c;
        longint mix [4];
        t_drive_set res;
        sp  = cfg_setpoint;
        err = saturate_q(sp - longint'(angle));
        law = saturate_q(fixed_mul(err, gain_err) - fixed_mul(rate, gain_rate)
                         + fixed_mul(sp, gain_ff));
        yaw_cmd = clamp_mag(law, lim_yaw);
        // per-axis clamps; yaw and pitch share the yaw/pitch limit
        s = clamp_mag(surge, lim_surge);
        y = clamp_mag(yaw_cmd, lim_yaw_pitch);
        p = clamp_mag(pitch, lim_yaw_pitch);
        r = clamp_mag(roll, lim_roll);
        mix[0] = s + y - p - r;
        mix[1] = s + y + p + r;
        mix[2] = s - y - p + r;
        mix[3] = s - y + p - r;
        res[0] = yaw_cmd[15:0];
        for (int i = 0; i < 4; i++) begin
            c = saturate_q(clamp_mag(mix[i], THR_LIMIT));
            c = fixed_mul(c, THR_GAIN);
            res[i + 1] = c[15:0];
        end
        return res;
    endfunction

    // Field-by-field compare against the oldest prediction
    task automatic compare_drives(input t_drive_set want, input t_drive_set got);
        for (int f = 0; f < 5; f++) begin
            if (got[f] !== want[f]) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("%0t: %s mismatch: expected %0d, got %0d", $realtime,
                             field_name[f], $signed(want[f]), $signed(got[f]));
                end
            end
        end
        o_checked++;
    endtask

    // Watch all three channels at the rising edge
    always @(posedge i_clk) begin : watch_channels
        t_drive_set got;
        if (!i_rst_n) begin
            cfg_setpoint  = RST_YAW_SETPOINT;
            gain_err      = RST_K_ERROR;
            gain_rate     = RST_K_RATE;
            gain_ff       = RST_K_FEEDFORWARD;
            lim_yaw       = RST_LIMIT;
            lim_surge     = RST_LIMIT;
            lim_yaw_pitch = RST_LIMIT;
            lim_roll      = RST_LIMIT;
        end else begin
            // register write; limits keep their low 15 bits
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_YAW_SETPOINT:    cfg_setpoint  = i_cfg_data;
                    REG_K_ERROR:         gain_err      = i_cfg_data;
                    REG_K_RATE:          gain_rate     = i_cfg_data;
                    REG_K_FEEDFORWARD:   gain_ff       = i_cfg_data;
                    REG_YAW_OUT_LIMIT:   lim_yaw       = i_cfg_data[14:0];
                    REG_SURGE_LIMIT:     lim_surge     = i_cfg_data[14:0];
                    REG_YAW_PITCH_LIMIT: lim_yaw_pitch = i_cfg_data[14:0];
                    REG_ROLL_LIMIT:      lim_roll      = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                drive_queue.push_back(predict_drives(i_yaw_angle, i_yaw_rate, i_surge_cmd,
                                                     i_pitch_cmd, i_roll_cmd));
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_thruster_d, i_thruster_c, i_thruster_b, i_thruster_a, i_yaw_drive};
                if (drive_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: output transfer with nothing expected, yaw_drive %0d",
                                 $realtime, $signed(i_yaw_drive));
                    end
                end else begin
                    compare_drives(drive_queue.pop_front(), got);
                end
            end
        end
        o_pending = drive_queue.size();
    end

endmodule

FILE: verif/rov_yaw_control_and_thruster_mix_test.sv
// Test top for the ROV yaw control and thruster mix block: drives register writes
// and sensor samples with random gaps; rywc_drive_checker does the checking.
// Depends on rywc_pkg, rov_yaw_control_and_thruster_mix and rywc_drive_checker.
`timescale 1ns / 1ps

module rov_yaw_control_and_thruster_mix_test;
    import rywc_pkg::*;

    // Indexes past the register map; writes there must be dropped
    localparam t_reg_idx REG_UNUSED_LO = 4'd8;
    localparam t_reg_idx REG_UNUSED_HI = 4'd15;
    localparam int       SAMPLE_TARGET = 700;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    t_reg_idx    cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_q88        yaw_angle;
    t_q88        yaw_rate;
    t_q88        surge_cmd;
    t_q88        pitch_cmd;
    t_q88        roll_cmd;
    logic        out_valid;
    logic        out_ready;
    t_q88        yaw_drive;
    t_q88        thr_a;
    t_q88        thr_b;
    t_q88        thr_c;
    t_q88        thr_d;

    int   fail_count;
    int   pending;
    int   checked;
    int   samples_sent;
    int   settings_run;
    logic calm;

    rov_yaw_control_and_thruster_mix dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_yaw_angle  (yaw_angle),
        .i_yaw_rate   (yaw_rate),
        .i_surge_cmd  (surge_cmd),
        .i_pitch_cmd  (pitch_cmd),
        .i_roll_cmd   (roll_cmd),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_yaw_drive  (yaw_drive),
        .o_thruster_a (thr_a),
        .o_thruster_b (thr_b),
        .o_thruster_c (thr_c),
        .o_thruster_d (thr_d)
    );

    rywc_drive_checker #(
        .THR_LIMIT (P_THRUSTER_LIMIT),
        .THR_GAIN  (P_THRUSTER_GAIN)
    ) drive_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_yaw_angle  (yaw_angle),
        .i_yaw_rate   (yaw_rate),
        .i_surge_cmd  (surge_cmd),
        .i_pitch_cmd  (pitch_cmd),
        .i_roll_cmd   (roll_cmd),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_yaw_drive  (yaw_drive),
        .i_thruster_a (thr_a),
        .i_thruster_b (thr_b),
        .i_thruster_c (thr_c),
        .i_thruster_d (thr_d),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int dice;
        if (calm) return 0;
        dice = $urandom_range(0, 99);
        if (dice < 65) return 0;
        if (dice < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sensor / command word: extremes, small values, full range
    function automatic t_q88 pick_q88();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            4, 5: return t_q88'($urandom_range(0, 1024) - 512);
            default: return t_q88'($urandom());
        endcase
    endfunction

    // Gains lean toward moderate values so the law does not always saturate
    function automatic t_q88 pick_gain();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0100;
            3: return 16'sh0000;
            4, 5, 6: return t_q88'($urandom_range(0, 1200) - 600);
            default: return t_q88'($urandom());
        endcase
    endfunction

    // Limit word, top bit included so that it gets dropped now and then
    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h8000;
            4, 5: return 16'($urandom_range(0, 1500));
            default: return 16'($urandom());
        endcase
    endfunction

    // One register write; starts and ends at a falling edge
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
    endtask

    // One sample transfer; valid stays high when the next one follows at once
    task automatic send_sample(input t_q88 a, input t_q88 r, input t_q88 s,
                               input t_q88 p, input t_q88 ro);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        yaw_angle <= a;
        yaw_rate  <= r;
        surge_cmd <= s;
        pitch_cmd <= p;
        roll_cmd  <= ro;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    // Stop sending and let the pipeline empty before touching registers
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        settings_run++;
    endtask

    // Random register set for one phase, sometimes a stray out-of-map write
    task automatic shuffle_config();
        if ($urandom_range(0, 1)) write_reg(REG_YAW_SETPOINT, pick_q88());
        if ($urandom_range(0, 1)) write_reg(REG_K_ERROR, pick_gain());
        if ($urandom_range(0, 1)) write_reg(REG_K_RATE, pick_gain());
        if ($urandom_range(0, 1)) write_reg(REG_K_FEEDFORWARD, pick_gain());
        if ($urandom_range(0, 2) == 0) write_reg(REG_YAW_OUT_LIMIT, pick_limit());
        if ($urandom_range(0, 2) == 0) write_reg(REG_SURGE_LIMIT, pick_limit());
        if ($urandom_range(0, 2) == 0) write_reg(REG_YAW_PITCH_LIMIT, pick_limit());
        if ($urandom_range(0, 2) == 0) write_reg(REG_ROLL_LIMIT, pick_limit());
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED_HI, 16'($urandom()));
    endtask

    // Output side back-pressure
    initial begin : out_stall
        int hold;
        hold      = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    initial begin : stimulus
        int phase_len;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_YAW_SETPOINT;
        cfg_data     = 16'h0000;
        in_valid     = 1'b0;
        yaw_angle    = 16'sh0000;
        yaw_rate     = 16'sh0000;
        surge_cmd    = 16'sh0000;
        pitch_cmd    = 16'sh0000;
        roll_cmd     = 16'sh0000;
        calm         = 1'b0;
        samples_sent = 0;
        settings_run = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: unity error gain, wide-open limits, zero, extreme and mixed inputs
        send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0000);
        send_sample(16'sh0001, 16'shFFFF, 16'shFFFF, 16'sh0001, 16'shFFFF);
        drain_pipe();

        // Extreme gains and every limit at zero: all drives forced to zero
        write_reg(REG_YAW_SETPOINT, 16'h8000);
        write_reg(REG_K_ERROR, 16'h7FFF);
        write_reg(REG_K_RATE, 16'h8000);
        write_reg(REG_K_FEEDFORWARD, 16'h7FFF);
        write_reg(REG_YAW_OUT_LIMIT, 16'h0000);
        write_reg(REG_SURGE_LIMIT, 16'h0000);
        write_reg(REG_YAW_PITCH_LIMIT, 16'h0000);
        write_reg(REG_ROLL_LIMIT, 16'h0000);
        send_sample(16'sh04D2, 16'shFFFB, 16'sh7FFF, 16'sh8000, 16'sh0064);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh0001, 16'shFFFF, 16'sh0000);
        drain_pipe();

        // Top bit of a limit dropped, then out-of-map writes that must not land
        write_reg(REG_YAW_SETPOINT, 16'h7FFF);
        write_reg(REG_K_ERROR, 16'h0100);
        write_reg(REG_K_RATE, 16'h7FFF);
        write_reg(REG_K_FEEDFORWARD, 16'h8000);
        write_reg(REG_YAW_OUT_LIMIT, 16'hFFFF);
        write_reg(REG_SURGE_LIMIT, 16'h83E8);
        write_reg(REG_YAW_PITCH_LIMIT, 16'h0200);
        write_reg(REG_ROLL_LIMIT, 16'h0100);
        write_reg(REG_UNUSED_LO, 16'h0000);
        write_reg(REG_UNUSED_HI, 16'h0000);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh0000, 16'sh8000, 16'sh03E8, 16'shFE00, 16'sh0100);
        send_sample(16'sh7FFF, 16'sh0000, 16'shFC18, 16'sh0200, 16'shFF00);
        send_sample(16'shFF00, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
        drain_pipe();

        // Random phases, each under a fresh register set
        while (samples_sent < SAMPLE_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            shuffle_config();
            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                send_sample(pick_q88(), pick_q88(), pick_q88(), pick_q88(), pick_q88());
            end
            drain_pipe();
        end

        $display("Run covered %0d samples under %0d register settings; %0d drive sets checked.",
                 samples_sent, settings_run, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("rov_yaw_control_and_thruster_mix_test: done, clean");
        end else begin
            $display("rov_yaw_control_and_thruster_mix_test: done, errors");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #1ms;
        $display("Timeout with %0d drive sets still outstanding.", pending);
        $display("rov_yaw_control_and_thruster_mix_test: done, errors");
        $finish;
    end

endmodule

FILE: rov_yaw_control_and_thruster_mix.f
+incdir+src
src/rywc_pkg.sv
src/rywc_yaw_law.sv
src/rywc_mixer.sv
src/rov_yaw_control_and_thruster_mix.sv
src/rywc_checker.sv
verif/rywc_drive_checker.sv
verif/rov_yaw_control_and_thruster_mix_test.sv
